FILE: hdl/pts_pkg.sv
`default_nettype none
package pts_pkg;

  typedef enum logic [2:0] {
    ACT_CREATE  = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_DELAY   = 3'd2,
    ACT_BLOCK   = 3'd3,
    ACT_UNBLOCK = 3'd4,
    ACT_PAUSE   = 3'd5,
    ACT_RESUME  = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_TIMED    = 2'd1,
    KIND_RESOURCE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_TICK_PERIOD  = 2'd0,
    CFG_SCHED_ENABLE = 2'd1,
    CFG_TOP_PRIORITY = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIMEOUT,
    ST_UNBLOCK,
    ST_WAKE,
    ST_PASS,
    ST_DONE
  } state_t;

  localparam int unsigned MIN_STACK_WORDS = 64;

endpackage
`default_nettype wire

FILE: hdl/pts_slot_table.sv
`default_nettype none
module pts_slot_table #(
  parameter int MAX_TASKS = 16,
  parameter int PRIO_BITS = 3,
  localparam int SW = $clog2(MAX_TASKS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [SW-1:0]        rd_slot,
  output logic      [PRIO_BITS-1:0] rd_prio,
  output pts_pkg::kind_t            rd_kind,
  output logic      [7:0]           rd_res,
  output logic                      rd_paused,
  output logic      [31:0]          rd_wait,
  input  wire logic [SW-1:0]        cur_slot,
  output logic                      cur_ready,
  output logic      [PRIO_BITS-1:0] cur_prio,
  input  wire logic                 wr_en,
  input  wire logic [SW-1:0]        wr_slot,
  input  wire logic [PRIO_BITS-1:0] wr_prio,
  input  wire pts_pkg::kind_t       wr_kind,
  input  wire logic [7:0]           wr_res,
  input  wire logic                 wr_paused,
  input  wire logic [31:0]          wr_wait
);

  logic [PRIO_BITS-1:0] prio_r   [MAX_TASKS];
  pts_pkg::kind_t       kind_r   [MAX_TASKS];
  logic [7:0]           res_r    [MAX_TASKS];
  logic                 paused_r [MAX_TASKS];
  logic [31:0]          wait_r   [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        prio_r[i]   <= '0;
        kind_r[i]   <= pts_pkg::KIND_NONE;
        res_r[i]    <= '0;
        paused_r[i] <= 1'b0;
        wait_r[i]   <= '0;
      end
    end else if (wr_en) begin
      prio_r[wr_slot]   <= wr_prio;
      kind_r[wr_slot]   <= wr_kind;
      res_r[wr_slot]    <= wr_res;
      paused_r[wr_slot] <= wr_paused;
      wait_r[wr_slot]   <= wr_wait;
    end
  end

  assign rd_prio   = prio_r[rd_slot];
  assign rd_kind   = kind_r[rd_slot];
  assign rd_res    = res_r[rd_slot];
  assign rd_paused = paused_r[rd_slot];
  assign rd_wait   = wait_r[rd_slot];
  assign cur_ready = (kind_r[cur_slot] == pts_pkg::KIND_NONE) && !paused_r[cur_slot];
  assign cur_prio  = prio_r[cur_slot];

endmodule
`default_nettype wire

FILE: hdl/priority_task_scheduler.sv
`default_nettype none
// Each action is one transaction. Create, resume, pause of a slot that is not running, a tick
// without a scheduling pass and an error go straight to the result; delay, block and pause of
// the running slot run a scheduling pass over the slots in use; a tick may sweep timeouts and
// then schedule; unblock searches for the waiter and wakes it, then runs a pass when the
// woken task outranks the running one. One slot a cycle goes through a single table read
// port. The block takes no new action until the result has been taken, so the next
// transaction can be accepted in the cycle after that.
module priority_task_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int PRIO_BITS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [3:0]  in_task_slot,
  input  wire logic [2:0]  in_new_priority,
  input  wire logic [15:0] in_stack_words,
  input  wire logic [31:0] in_delay_ticks,
  input  wire logic [7:0]  in_resource_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic             out_switched,
  output logic [3:0]       out_running_slot,
  output logic [3:0]       out_affected_slot,
  output logic             out_woke,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  pts_pkg::state_t state_r, state_nxt;
  logic [15:0] tick_period_r;
  logic        sched_enable_r;
  logic [2:0]  top_priority_r;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [PRIO_BITS-1:0] bprio_r, bprio_nxt;
  logic          found_r, found_nxt;
  logic          full_r, full_nxt;
  logic [7:0]    res_r;
  logic          status_r, status_nxt, switched_r, switched_nxt, woke_r, woke_nxt;
  logic [SW-1:0] aff_r, aff_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [SW-1:0]        rd_slot;
  logic [PRIO_BITS-1:0] rd_prio, cur_prio;
  pts_pkg::kind_t       rd_kind;
  logic [7:0]           rd_res;
  logic                 rd_paused, cur_ready;
  logic [31:0]          rd_wait;
  logic                 wr_en;
  logic [SW-1:0]        wr_slot;
  logic [PRIO_BITS-1:0] wr_prio;
  pts_pkg::kind_t       wr_kind;
  logic [7:0]           wr_res;
  logic                 wr_paused;
  logic [31:0]          wr_wait;

  logic [CW-1:0]        next_idx;
  logic                 rd_ready;
  logic [SW-1:0]        ts;

  pts_slot_table #(.MAX_TASKS(MAX_TASKS), .PRIO_BITS(PRIO_BITS)) u_table (
    .clk, .rst_n, .rd_slot, .rd_prio, .rd_kind, .rd_res, .rd_paused, .rd_wait,
    .cur_slot(cur_r), .cur_ready, .cur_prio,
    .wr_en, .wr_slot, .wr_prio, .wr_kind, .wr_res, .wr_paused, .wr_wait
  );

  assign in_ready  = (state_r == pts_pkg::ST_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_switched = switched_r;
  assign out_running_slot = 4'(cur_r);
  assign out_affected_slot = 4'(aff_r);
  assign out_woke = woke_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r  <= 16'd1;
      sched_enable_r <= 1'b0;
      top_priority_r <= 3'd3;
    end else if (cfg_valid) begin
      case (pts_pkg::cfg_idx_t'(cfg_index))
        pts_pkg::CFG_TICK_PERIOD:  tick_period_r  <= cfg_data;
        pts_pkg::CFG_SCHED_ENABLE: sched_enable_r <= cfg_data[0];
        pts_pkg::CFG_TOP_PRIORITY: top_priority_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pts_pkg::ST_IDLE;
      tick_count_r <= '0;
      cur_r        <= '0;
      used_r       <= CW'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      cur_r        <= cur_nxt;
      used_r       <= used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    best_r <= best_nxt;
    bprio_r <= bprio_nxt;
    found_r <= found_nxt;
    full_r <= full_nxt;
    status_r <= status_nxt;
    switched_r <= switched_nxt;
    woke_r <= woke_nxt;
    aff_r <= aff_nxt;
    if (in_valid && in_ready) res_r <= in_resource_id;
  end

  assign next_idx = (CW'(idx_r) + CW'(1) >= used_r) ? '0 : CW'(idx_r) + CW'(1);
  assign rd_ready = (rd_kind == pts_pkg::KIND_NONE) && !rd_paused;
  assign ts = in_task_slot[SW-1:0];

  always_comb begin
    state_nxt = state_r;
    tick_count_nxt = tick_count_r;
    cur_nxt = cur_r;
    used_nxt = used_r;
    out_valid_nxt = out_valid_r && !out_ready;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    best_nxt = best_r;
    bprio_nxt = bprio_r;
    found_nxt = found_r;
    full_nxt = full_r;
    status_nxt = status_r;
    switched_nxt = switched_r;
    woke_nxt = woke_r;
    aff_nxt = aff_r;
    rd_slot = idx_r;
    wr_en = 1'b0;
    wr_slot = idx_r;
    wr_prio = rd_prio;
    wr_kind = rd_kind;
    wr_res = rd_res;
    wr_paused = rd_paused;
    wr_wait = rd_wait;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          status_nxt = 1'b0;
          switched_nxt = 1'b0;
          woke_nxt = 1'b0;
          aff_nxt = '0;
          state_nxt = pts_pkg::ST_DONE;
          rd_slot = ts;
          case (pts_pkg::action_t'(in_action))
            pts_pkg::ACT_CREATE: begin
              if (in_stack_words < 16'(pts_pkg::MIN_STACK_WORDS) ||
                  in_new_priority > top_priority_r || used_r >= CW'(MAX_TASKS)) begin
                status_nxt = 1'b1;
              end else begin
                wr_en = 1'b1;
                wr_slot = used_r[SW-1:0];
                wr_prio = PRIO_BITS'(in_new_priority);
                wr_kind = pts_pkg::KIND_NONE;
                wr_res = '0;
                wr_paused = 1'b0;
                wr_wait = '0;
                aff_nxt = used_r[SW-1:0];
                used_nxt = used_r + CW'(1);
              end
            end
            pts_pkg::ACT_TICK: begin
              tick_count_nxt = (tick_count_r != 16'hFFFF) ? tick_count_r + 16'd1 : tick_count_r;
              if (tick_count_nxt >= tick_period_r && sched_enable_r) begin
                tick_count_nxt = '0;
                switched_nxt = 1'b1;
                idx_nxt = '0;
                cnt_nxt = '0;
                state_nxt = pts_pkg::ST_TIMEOUT;
              end
            end
            pts_pkg::ACT_DELAY, pts_pkg::ACT_BLOCK: begin
              rd_slot = cur_r;
              wr_en = 1'b1;
              wr_slot = cur_r;
              if (pts_pkg::action_t'(in_action) == pts_pkg::ACT_DELAY) begin
                wr_kind = pts_pkg::KIND_TIMED;
                wr_wait = (in_delay_ticks == '0) ? 32'd1 : in_delay_ticks;
              end else begin
                wr_kind = pts_pkg::KIND_RESOURCE;
                wr_res = in_resource_id;
              end
              switched_nxt = 1'b1;
              state_nxt = pts_pkg::ST_PASS;
              idx_nxt = '0;
              cnt_nxt = '0;
            end
            pts_pkg::ACT_UNBLOCK: begin
              found_nxt = 1'b0;
              best_nxt = '0;
              cnt_nxt = '0;
              idx_nxt = (CW'(cur_r) + CW'(1) >= used_r) ? '0 : SW'(CW'(cur_r) + CW'(1));
              state_nxt = pts_pkg::ST_UNBLOCK;
            end
            pts_pkg::ACT_PAUSE: begin
              if (CW'(ts) >= used_r || int'(in_task_slot) >= MAX_TASKS || rd_paused) begin
                status_nxt = 1'b1;
              end else begin
                wr_en = 1'b1;
                wr_slot = ts;
                wr_paused = 1'b1;
                if (ts == cur_r) begin
                  switched_nxt = 1'b1;
                  state_nxt = pts_pkg::ST_PASS;
                  idx_nxt = '0;
                  cnt_nxt = '0;
                end
              end
            end
            pts_pkg::ACT_RESUME: begin
              if (CW'(ts) >= used_r || int'(in_task_slot) >= MAX_TASKS || !rd_paused) begin
                status_nxt = 1'b1;
              end else begin
                wr_en = 1'b1;
                wr_slot = ts;
                wr_paused = 1'b0;
              end
            end
            default: status_nxt = 1'b1;
          endcase
        end
      end
      pts_pkg::ST_TIMEOUT: begin
        if (idx_r != cur_r && rd_kind == pts_pkg::KIND_TIMED && !rd_paused &&
            rd_wait != '0) begin
          wr_en = 1'b1;
          wr_wait = rd_wait - 32'd1;
          if (rd_wait == 32'd1) wr_kind = pts_pkg::KIND_NONE;
        end
        if (CW'(idx_r) + CW'(1) >= used_r) begin
          idx_nxt = '0;
          cnt_nxt = '0;
          state_nxt = pts_pkg::ST_PASS;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      pts_pkg::ST_UNBLOCK: begin
        if (rd_kind == pts_pkg::KIND_RESOURCE && rd_res == res_r &&
            (!found_r || rd_prio > bprio_r)) begin
          found_nxt = 1'b1;
          best_nxt = idx_r;
          bprio_nxt = rd_prio;
        end
        idx_nxt = next_idx[SW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r + CW'(1) >= used_r) state_nxt = pts_pkg::ST_WAKE;
      end
      pts_pkg::ST_WAKE: begin
        rd_slot = best_r;
        if (found_r) begin
          wr_en = 1'b1;
          wr_slot = best_r;
          wr_kind = pts_pkg::KIND_NONE;
          woke_nxt = 1'b1;
          aff_nxt = best_r;
          if (bprio_r > cur_prio) begin
            switched_nxt = 1'b1;
            idx_nxt = '0;
            cnt_nxt = '0;
            state_nxt = pts_pkg::ST_PASS;
          end else begin
            state_nxt = pts_pkg::ST_DONE;
          end
        end else begin
          state_nxt = pts_pkg::ST_DONE;
        end
      end
      pts_pkg::ST_PASS: begin
        // The first cycle latches the start slot; later cycles scan the ring.
        if (cnt_r == '0) begin
          full_nxt = !cur_ready;
          best_nxt = cur_ready ? cur_r : '0;
          bprio_nxt = cur_ready ? cur_prio : '0;
          rd_slot = best_nxt;
          idx_nxt = cur_ready ? cur_r : '0;
          cnt_nxt = CW'(1);
          if (used_r == CW'(1)) begin
            cur_nxt = best_nxt;
            state_nxt = pts_pkg::ST_DONE;
          end
        end else begin
          rd_slot = full_r ? SW'(cnt_r) : next_idx[SW-1:0];
          if (rd_ready && rd_prio >= bprio_r) begin
            best_nxt = rd_slot;
            bprio_nxt = rd_prio;
          end
          idx_nxt = rd_slot;
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r + CW'(1) >= used_r) begin
            cur_nxt = best_nxt;
            state_nxt = pts_pkg::ST_DONE;
          end
        end
      end
      pts_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = pts_pkg::ST_IDLE;
      end
      default: state_nxt = pts_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pts_pkg::ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r >= CW'(1)) && (used_r <= CW'(MAX_TASKS))) else $error("slot count out of range");
  a_cur_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(cur_r) < used_r) else $error("running slot not in use");
  a_done_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pts_pkg::ST_DONE) |=> out_valid) else $error("result lost");
`endif

endmodule
`default_nettype wire
